[hw/rtl/bba_pkg.sv]
// Package for the buddy bitmap allocator.
// Holds the operation codes and the result word type; no dependencies.
`default_nettype none
package bba_pkg;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [10:0] free_left;
    logic [9:0]  seg_offset;
    logic        ok;
  } bba_result_t;
endpackage
`default_nettype wire

[hw/rtl/bba_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[hw/rtl/buddy_bitmap_allocator.sv]
// Buddy bitmap allocator top level; depends on bba_pkg and bba_ram.
// After reset a clearing pass over all 2*LEAF-1 bits (511 by default) sets
// every free bit; no word is accepted meanwhile.
// An allocate scans its level one bit a cycle, then writes the subtree and
// ancestors one bit a cycle; a free writes the subtree; one word at a time.
`default_nettype none
module buddy_bitmap_allocator #(
  parameter int REGION_BYTES  = 1024,
  parameter int MIN_SEG_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,  // operation, size_bytes[10:0], offset[15:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata  // ok, seg_offset[9:0], free_left[10:0]
);
  import bba_pkg::*;

  localparam int LEAF  = REGION_BYTES / MIN_SEG_BYTES;
  localparam int TOTAL = 2 * LEAF - 1;
  localparam int LEVELS = $clog2(LEAF) + 1;
  localparam int AW = $clog2(TOTAL);
  localparam int LW = $clog2(LEVELS + 1);
  localparam int MSH = $clog2(MIN_SEG_BYTES);
  localparam int CW = $clog2(REGION_BYTES + 1);
  localparam int IW = $clog2(LEAF + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SIZE, S_SCAN, S_SUB, S_UP, S_DONE
  } state_t;

  state_t state_r;
  logic [AW-1:0] clr_r, addr;
  logic we, wdata, rdata;
  logic op_r;
  logic [10:0] size_r;
  logic [15:0] offs_r;
  logic [LW-1:0] lvl_r, l_r;
  logic [IW-1:0] idx_r, cnt_r, j_r, span_r;
  logic [AW-1:0] base_r, lbase_r;
  logic [CW-1:0] fc_r;
  logic [16:0] segsz_r;
  logic rd_pend_r;
  bba_result_t res_r;

  logic [AW-1:0] cnt_now;
  assign cnt_now = AW'(LEAF >> lvl_r);

  always_comb begin
    we = 1'b0;
    wdata = 1'b0;
    addr = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wdata = 1'b1;
      end
      S_SCAN: addr = base_r + AW'(idx_r);
      S_SUB: begin
        we = 1'b1;
        wdata = op_r;
        addr = lbase_r + AW'(idx_r * span_r) + AW'(j_r);
      end
      S_UP: begin
        we = (l_r != LW'(LEVELS - 1));
        addr = lbase_r + AW'(idx_r);
      end
      default: ;
    endcase
  end

  bba_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DONE);
  assign out_tdata = {2'b0, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      fc_r <= CW'(REGION_BYTES);
      rd_pend_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(TOTAL - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tdata[0];
          size_r <= in_tdata[11:1];
          offs_r <= in_tdata[27:12];
          lvl_r <= '0;
          base_r <= '0;
          segsz_r <= 17'(MIN_SEG_BYTES);
          state_r <= S_SIZE;
        end
        S_SIZE: begin
          // One level per cycle until the segment covers the size.
          if (segsz_r < 17'(size_r)) begin
            if (segsz_r >= 17'(REGION_BYTES)) begin
              res_r <= '{free_left: 11'(fc_r), seg_offset: '0, ok: 1'b0};
              state_r <= S_DONE;
            end else begin
              base_r <= base_r + cnt_now;
              lvl_r <= lvl_r + 1'b1;
              segsz_r <= segsz_r << 1;
            end
          end else if (op_r == OP_ALLOC) begin
            idx_r <= '0;
            rd_pend_r <= 1'b0;
            if (17'(size_r) > 17'(fc_r)) begin
              res_r <= '{free_left: 11'(fc_r), seg_offset: '0, ok: 1'b0};
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end else if (17'(offs_r) >= 17'(REGION_BYTES)) begin
            res_r <= '{free_left: 11'(fc_r), seg_offset: '0, ok: 1'b0};
            state_r <= S_DONE;
          end else begin
            idx_r <= IW'(offs_r >> (MSH + lvl_r));
            l_r <= lvl_r;
            lbase_r <= '0;
            span_r <= IW'(1) << lvl_r;
            j_r <= '0;
            cnt_r <= '0;
            state_r <= S_SUB;
          end
        end
        S_SCAN: begin
          rd_pend_r <= 1'b1;
          if (rd_pend_r && rdata) begin
            idx_r <= idx_r - 1'b1;
            lbase_r <= '0;
            span_r <= IW'(1) << lvl_r;
            j_r <= '0;
            cnt_r <= '0;
            state_r <= S_SUB;
          end else if (rd_pend_r && idx_r == IW'(cnt_now)) begin
            res_r <= '{free_left: 11'(fc_r), seg_offset: '0, ok: 1'b0};
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SUB: begin
          // cnt_r counts levels from the leaves up to lvl_r.
          if (j_r == span_r - 1'b1) begin
            j_r <= '0;
            if (cnt_r == IW'(lvl_r)) begin
              if (op_r == OP_FREE) begin
                fc_r <= (18'(fc_r) + 18'(segsz_r) > 18'(REGION_BYTES))
                        ? CW'(REGION_BYTES) : CW'(18'(fc_r) + 18'(segsz_r));
                res_r <= '{free_left: 11'((18'(fc_r) + 18'(segsz_r)
                           > 18'(REGION_BYTES)) ? REGION_BYTES
                           : 18'(fc_r) + 18'(segsz_r)), seg_offset: '0, ok: 1'b1};
                state_r <= S_DONE;
              end else begin
                fc_r <= (17'(fc_r) > segsz_r) ? CW'(17'(fc_r) - segsz_r) : '0;
                res_r.seg_offset <= 10'(27'(idx_r) * 27'(segsz_r));
                res_r.ok <= 1'b1;
                l_r <= lvl_r;
                lbase_r <= base_r + cnt_now;
                idx_r <= idx_r >> 1;
                state_r <= S_UP;
              end
            end else begin
              lbase_r <= lbase_r + AW'(LEAF >> cnt_r);
              cnt_r <= cnt_r + 1'b1;
              span_r <= span_r >> 1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_UP: begin
          if (l_r + 1'b1 >= LW'(LEVELS - 1)) begin
            res_r.free_left <= 11'(fc_r);
            state_r <= S_DONE;
          end else begin
            l_r <= l_r + 1'b1;
            lbase_r <= lbase_r + AW'(LEAF >> (l_r + 1'b1));
            idx_r <= idx_r >> 1;
          end
        end
        S_DONE: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
